FILE: rtl/core/rrf_pkg.sv
`default_nettype none

package rrf_pkg;

    // Window length in bytes; the cell chain has one cell per byte
    localparam int WINDOW_BYTES = 64;

    // Fingerprint width equals the degree of the reduction polynomial
    localparam int PRINT_W = 53;
    localparam logic [PRINT_W:0] POLY = 54'h3DA3358B4DC173;

    // Distance in bit positions between the oldest window byte and the newest
    localparam int SLIDE_EXP = 8 * (WINDOW_BYTES - 1);

    typedef logic [PRINT_W-1:0] t_print;
    typedef logic [7:0]         t_byte;

    // Per-item controls shared by every cell of the chain
    typedef struct packed {
        logic shift;
        logic restart;
    } t_shift_ctl;

    // x^e mod POLY, evaluated at elaboration
    function automatic t_print pow_mod(input int e);
        logic [PRINT_W:0] r;
        r = {{PRINT_W{1'b0}}, 1'b1};
        for (int i = 0; i < e; i++) begin
            r = {r[PRINT_W-1:0], 1'b0};
            if (r[PRINT_W]) begin
                r = r ^ POLY;
            end
        end
        return r[PRINT_W-1:0];
    endfunction

    // Basis of the reduction table: x^(53+k) mod POLY
    localparam t_print REDUCE_BASIS [8] = '{
        pow_mod(PRINT_W + 0), pow_mod(PRINT_W + 1), pow_mod(PRINT_W + 2),
        pow_mod(PRINT_W + 3), pow_mod(PRINT_W + 4), pow_mod(PRINT_W + 5),
        pow_mod(PRINT_W + 6), pow_mod(PRINT_W + 7)
    };

    // Basis of the slide-out table: x^(8*(WINDOW_BYTES-1)+k) mod POLY
    localparam t_print SLIDE_BASIS [8] = '{
        pow_mod(SLIDE_EXP + 0), pow_mod(SLIDE_EXP + 1), pow_mod(SLIDE_EXP + 2),
        pow_mod(SLIDE_EXP + 3), pow_mod(SLIDE_EXP + 4), pow_mod(SLIDE_EXP + 5),
        pow_mod(SLIDE_EXP + 6), pow_mod(SLIDE_EXP + 7)
    };

    // Reduction table entry: top byte times x^53 mod POLY (GF(2) linear)
    function automatic t_print rrf_reduce(input t_byte b);
        t_print acc;
        acc = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ REDUCE_BASIS[k];
            end
        end
        return acc;
    endfunction

    // Slide-out table entry: contribution of the oldest byte to the print
    function automatic t_print rrf_slide_out(input t_byte b);
        t_print acc;
        acc = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ SLIDE_BASIS[k];
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rrf_cell.sv
`default_nettype none

module rrf_cell
    import rrf_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_shift_ctl i_ctl,
    input  t_byte      i_rst_val,
    input  t_byte      i_ctx_val,
    input  t_byte      i_prev,
    output t_byte      o_byte
);

    t_byte r_byte;
    t_byte n_byte;

    // On a shift, take the neighbor's byte, or the initial-context byte on restart; else hold
    always_comb begin
        n_byte = r_byte;
        if (i_ctl.shift) begin
            n_byte = i_ctl.restart ? i_ctx_val : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= i_rst_val;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

FILE: rtl/core/rrf_print.sv
`default_nettype none

module rrf_print
    import rrf_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_accept,
    input  wire    i_restart,
    input  t_byte  i_data_byte,
    input  t_byte  i_old_byte,
    output t_print o_next_print
);

    t_print r_print;
    t_print w_base;
    t_print w_cancel;
    t_byte  w_top;
    t_print n_print;

    // Start from the initial context on restart: fingerprint of the byte 1
    assign w_base = i_restart ? t_print'(1) : r_print;

    // Cancel the oldest byte, then shift in the new one and fold the top byte
    assign w_cancel = w_base ^ rrf_slide_out(i_old_byte);
    assign w_top    = w_cancel[PRINT_W-1 -: 8];
    assign n_print  = {w_cancel[PRINT_W-9:0], i_data_byte} ^ rrf_reduce(w_top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_print <= t_print'(1);
        end else if (i_accept) begin
            r_print <= n_print;
        end
    end

    assign o_next_print = n_print;

`ifndef SYNTH
    // Restart followed by a zero byte leaves x^8 as the fingerprint
    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_restart && (i_data_byte == 8'd0)) |=> (r_print == t_print'(256)))
        else $error("fingerprint after restart and zero byte is wrong");

    // Hold the fingerprint between transactions
    a_hold_print: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_print))
        else $error("fingerprint changed without a transaction");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/rrf_skid.sv
`default_nettype none

module rrf_skid
    import rrf_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_valid,
    input  t_print i_data,
    output logic   o_accept,
    output logic   o_full,
    output logic   o_valid,
    output t_print o_data,
    input  wire    i_stall
);

    logic   r_out_valid;
    t_print r_out_data;
    logic   r_skid_valid;
    t_print r_skid_data;
    logic   w_take;

    assign w_take   = r_out_valid && !i_stall;
    assign o_accept = i_valid && !r_skid_valid;

    // Control: fill the output register first, park in the skid stage on stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (o_accept) begin
            if (r_out_valid && !w_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (o_accept) begin
            if (r_out_valid && !w_take) begin
                r_skid_data <= i_data;
            end else begin
                r_out_data <= i_data;
            end
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

`ifndef SYNTH
    // The skid stage only holds data behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage valid with empty output register");

    // An accepted transaction always shows up at the output
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_accept |=> r_out_valid)
        else $error("accepted transaction lost");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/rabin_rolling_fingerprint.sv
// Rolling Rabin fingerprint over the last 64 bytes of a stream, modulo the
// degree-53 polynomial 0x3DA3358B4DC173, one 53-bit fingerprint per input
// byte. The block takes one byte per clock cycle while o_stall is low; each
// result is registered in the output register, or in the skid entry while
// the consumer stalls. The next fingerprint (slide-out fold of the oldest
// byte, shift, reduction fold of the top byte) is formed combinationally;
// the window lives in a chain of byte cells that shifts once per
// transaction. A two-entry output buffer keeps input acceptance going while
// the consumer stalls; o_stall rises only when both entries are full. With
// i_restart high the window and fingerprint return to the reset context
// (all-zero window with the byte 1 slid in) before that byte is processed.
`default_nettype none

module rabin_rolling_fingerprint
    import rrf_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_stall,
    input  wire  [7:0]   i_data_byte,
    input  wire          i_restart,
    output logic         o_valid,
    input  wire          i_stall,
    output logic [52:0]  o_fingerprint
);

    logic       w_accept;
    logic       w_full;
    t_shift_ctl w_ctl;
    t_byte      w_win [WINDOW_BYTES];
    t_byte      w_old;
    t_print     w_next_print;

    assign w_ctl.shift   = w_accept;
    assign w_ctl.restart = i_restart;

    // Window chain: cell 0 holds the newest byte, the last cell the oldest
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_BYTES; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                rrf_cell u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctl     (w_ctl),
                    .i_rst_val (t_byte'(1)),
                    .i_ctx_val (i_data_byte),
                    .i_prev    (i_data_byte),
                    .o_byte    (w_win[gi])
                );
            end else begin : g_body
                rrf_cell u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctl     (w_ctl),
                    .i_rst_val (t_byte'(0)),
                    .i_ctx_val ((gi == 1) ? t_byte'(1) : t_byte'(0)),
                    .i_prev    (w_win[gi-1]),
                    .o_byte    (w_win[gi])
                );
            end
        end
    endgenerate

    // Drop the oldest byte; after a restart the oldest byte is zero
    assign w_old = i_restart ? t_byte'(0) : w_win[WINDOW_BYTES-1];

    rrf_print u_print (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_restart    (i_restart),
        .i_data_byte  (i_data_byte),
        .i_old_byte   (w_old),
        .o_next_print (w_next_print)
    );

    rrf_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_data   (w_next_print),
        .o_accept (w_accept),
        .o_full   (w_full),
        .o_valid  (o_valid),
        .o_data   (o_fingerprint),
        .i_stall  (i_stall)
    );

    assign o_stall = w_full;

endmodule

`default_nettype wire
